// File: rtl/core/sqmix_pkg.sv
`timescale 1ns / 1ps

package sqmix_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CH_W = 2;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  localparam int MODE_W = 2;
  localparam int ADDR_W = 7;
  localparam int DATA_W = 8;
  localparam int SAMPLE_W = 14;
  localparam int STEP_W = 10;
  localparam int ACC_W = 16;
  localparam int PHASE_W = 9;
  localparam int REG_DEPTH = 32;
  localparam int REG_AW = 5;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic CFG_IDX_TICK_STEP = 1'b0;
  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 10'd22;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_CHAN_LO = 7'h20;
  localparam logic [ADDR_W-1:0] ADDR_CHAN_HI = 7'h3F;
  localparam logic [ADDR_W-1:0] ADDR_ATTEN_LO = 7'h40;
  localparam logic [ADDR_W-1:0] ADDR_ATTEN_HI = 7'h43;
  localparam logic [ADDR_W-1:0] ADDR_PAN = 7'h44;
  localparam logic [ADDR_W-1:0] ADDR_MUTE = 7'h50;

  localparam logic [2:0] REG_VOLUME = 3'd0;
  localparam logic [2:0] REG_OUTPUT = 3'd2;
  localparam logic [2:0] REG_CONTROL1 = 3'd5;
  localparam logic [2:0] REG_COUNTER = 3'd6;

  localparam logic [2:0] LINK_MODE_HOLD = 3'd7;
  localparam int COUNT_EN_BIT = 3;
  localparam logic [3:0] FULL_SCALE = 4'd15;
  localparam logic [ACC_W-1:0] ACC_MAX = 16'hFFFF;
  localparam logic [ACC_W-1:0] ACC_RESIDUE_LIMIT = 16'd64;
  localparam logic [PHASE_W-1:0] PHASE_LIMIT = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_RD_C1,
    ST_RD_PER,
    ST_RD_VOL,
    ST_STEP,
    ST_FIN,
    ST_RD_OUT,
    ST_MIX,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    RSEL_BUS,
    RSEL_C1,
    RSEL_PER,
    RSEL_VOL,
    RSEL_OUT
  } rsel_t;

  typedef struct packed {
    logic  capture;
    logic  bus_access;
    rsel_t rsel;
    logic  start_chan;
    logic  step;
    logic  finish;
    logic  mix;
    logic  load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic chan_en;
    logic chan_hold;
    logic units_left;
    logic last_ch;
    logic out_free;
  } dp_status_t;

endpackage

// File: rtl/core/sqmix_if.sv
`timescale 1ns / 1ps

interface sqmix_in_if;
  logic                             valid;
  logic                             ready;
  logic [sqmix_pkg::MODE_W-1:0]     mode;
  logic [sqmix_pkg::ADDR_W-1:0]     address;
  logic [sqmix_pkg::DATA_W-1:0]     write_data;

  modport source(output valid, mode, address, write_data, input ready);
  modport sink(input valid, mode, address, write_data, output ready);
endinterface

interface sqmix_out_if;
  logic                                valid;
  logic                                ready;
  logic [sqmix_pkg::DATA_W-1:0]        read_data;
  logic signed [sqmix_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [sqmix_pkg::SAMPLE_W-1:0] right_sample;

  modport source(output valid, read_data, left_sample, right_sample, input ready);
  modport sink(input valid, read_data, left_sample, right_sample, output ready);
endinterface

// File: rtl/core/sqmix_ctrl.sv
`timescale 1ns / 1ps

module sqmix_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sqmix_pkg::dp_status_t  st,
  output sqmix_pkg::ctrl_cmd_t   cmd
);

  sqmix_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqmix_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sqmix_pkg::ST_IDLE: begin
        if (in_valid) state_next = sqmix_pkg::ST_ACCESS;
      end
      sqmix_pkg::ST_ACCESS: begin
        state_next = st.is_tick ? sqmix_pkg::ST_RD_C1 : sqmix_pkg::ST_RESULT;
      end
      sqmix_pkg::ST_RD_C1:  state_next = sqmix_pkg::ST_RD_PER;
      sqmix_pkg::ST_RD_PER: state_next = sqmix_pkg::ST_RD_VOL;
      sqmix_pkg::ST_RD_VOL: begin
        if (!st.chan_en || st.chan_hold) state_next = sqmix_pkg::ST_RD_OUT;
        else state_next = sqmix_pkg::ST_STEP;
      end
      sqmix_pkg::ST_STEP: begin
        if (!st.units_left) state_next = sqmix_pkg::ST_FIN;
      end
      sqmix_pkg::ST_FIN:    state_next = sqmix_pkg::ST_RD_OUT;
      sqmix_pkg::ST_RD_OUT: state_next = sqmix_pkg::ST_MIX;
      sqmix_pkg::ST_MIX: begin
        state_next = st.last_ch ? sqmix_pkg::ST_RESULT : sqmix_pkg::ST_RD_C1;
      end
      sqmix_pkg::ST_RESULT: begin
        if (st.out_free) state_next = sqmix_pkg::ST_IDLE;
      end
      default: state_next = sqmix_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.rsel       = sqmix_pkg::RSEL_BUS;
    case (state)
      sqmix_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      sqmix_pkg::ST_ACCESS: cmd.bus_access = 1'b1;
      sqmix_pkg::ST_RD_C1:  cmd.rsel = sqmix_pkg::RSEL_C1;
      sqmix_pkg::ST_RD_PER: cmd.rsel = sqmix_pkg::RSEL_PER;
      sqmix_pkg::ST_RD_VOL: begin
        cmd.rsel       = sqmix_pkg::RSEL_VOL;
        cmd.start_chan = 1'b1;
      end
      sqmix_pkg::ST_STEP:   cmd.step = st.units_left;
      sqmix_pkg::ST_FIN:    cmd.finish = 1'b1;
      sqmix_pkg::ST_RD_OUT: cmd.rsel = sqmix_pkg::RSEL_OUT;
      sqmix_pkg::ST_MIX:    cmd.mix = 1'b1;
      sqmix_pkg::ST_RESULT: cmd.load_out = st.out_free;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/sqmix_dp.sv
`timescale 1ns / 1ps

module sqmix_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  sqmix_pkg::ctrl_cmd_t                   cmd,
  output sqmix_pkg::dp_status_t                  st,
  input  logic [sqmix_pkg::STEP_W-1:0]           tick_step,
  input  logic [sqmix_pkg::MODE_W-1:0]           in_mode,
  input  logic [sqmix_pkg::ADDR_W-1:0]           in_address,
  input  logic [sqmix_pkg::DATA_W-1:0]           in_write_data,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [sqmix_pkg::DATA_W-1:0]           out_read_data,
  output logic signed [sqmix_pkg::SAMPLE_W-1:0]  out_left_sample,
  output logic signed [sqmix_pkg::SAMPLE_W-1:0]  out_right_sample
);

  // architectural state
  logic [sqmix_pkg::DATA_W-1:0]  chan_regs [sqmix_pkg::REG_DEPTH];
  logic [sqmix_pkg::DATA_W-1:0]  atten [4];
  logic [sqmix_pkg::DATA_W-1:0]  pan_enable;
  logic [sqmix_pkg::DATA_W-1:0]  mute_mask;
  logic [sqmix_pkg::ACC_W-1:0]   tick_accum [4];
  logic [sqmix_pkg::PHASE_W-1:0] phase_count [4];

  // working registers
  logic [sqmix_pkg::MODE_W-1:0]  item_mode;
  logic [sqmix_pkg::ADDR_W-1:0]  item_addr;
  logic [sqmix_pkg::DATA_W-1:0]  item_data;
  logic [sqmix_pkg::CH_W-1:0]    ch;
  logic [sqmix_pkg::DATA_W-1:0]  c1;
  logic [sqmix_pkg::DATA_W-1:0]  per;
  logic [sqmix_pkg::DATA_W-1:0]  vol;
  logic [sqmix_pkg::DATA_W-1:0]  raw;
  logic [sqmix_pkg::ACC_W-1:0]   acc;
  logic [sqmix_pkg::PHASE_W-1:0] cnt;
  logic                          second_half;
  logic [sqmix_pkg::DATA_W-1:0]  rd_data;
  logic signed [sqmix_pkg::SAMPLE_W-1:0] left_sum;
  logic signed [sqmix_pkg::SAMPLE_W-1:0] right_sum;

  logic                          item_tick;
  logic [sqmix_pkg::REG_AW-1:0]  raddr;
  logic [sqmix_pkg::DATA_W-1:0]  rbyte;
  logic [1:0]                    aidx;
  logic [sqmix_pkg::DATA_W-1:0]  abyte;
  logic [sqmix_pkg::ACC_W-1:0]   unit;
  logic                          units_left;
  logic [sqmix_pkg::PHASE_W-1:0] half;
  logic [sqmix_pkg::PHASE_W-1:0] per9;
  logic [sqmix_pkg::ACC_W:0]     acc_sum;
  logic [sqmix_pkg::ACC_W-1:0]   acc_sat;
  logic [sqmix_pkg::PHASE_W-1:0] cnt_end;
  logic                          wen;
  logic [sqmix_pkg::REG_AW-1:0]  waddr;
  logic [sqmix_pkg::DATA_W-1:0]  wdata;
  logic [sqmix_pkg::DATA_W-1:0]  rd_next;
  logic [3:0]                    lscale;
  logic [3:0]                    rscale;
  logic signed [12:0]            lprod;
  logic signed [12:0]            rprod;

  assign item_tick = (item_mode == sqmix_pkg::MODE_TICK);

  always_comb begin
    case (cmd.rsel)
      sqmix_pkg::RSEL_C1:  raddr = {ch, sqmix_pkg::REG_CONTROL1};
      sqmix_pkg::RSEL_PER: raddr = {ch, sqmix_pkg::REG_COUNTER};
      sqmix_pkg::RSEL_VOL: raddr = {ch, sqmix_pkg::REG_VOLUME};
      sqmix_pkg::RSEL_OUT: raddr = {ch, sqmix_pkg::REG_OUTPUT};
      default:             raddr = item_addr[sqmix_pkg::REG_AW-1:0];
    endcase
  end

  assign rbyte = chan_regs[raddr];
  assign aidx  = item_tick ? ch : item_addr[1:0];
  assign abyte = atten[aidx];

  assign unit       = sqmix_pkg::ACC_W'(1) << c1[2:0];
  assign units_left = (acc >= unit);
  assign per9       = {1'b0, per};
  assign half       = {2'b00, per[7:1]};
  assign acc_sum    = {1'b0, tick_accum[ch]} + {7'b0, tick_step};
  assign acc_sat    = acc_sum[sqmix_pkg::ACC_W] ? sqmix_pkg::ACC_MAX
                                                : acc_sum[sqmix_pkg::ACC_W-1:0];
  assign cnt_end    = (second_half && cnt >= per9) ? '0 : cnt;

  always_comb begin
    wen   = 1'b0;
    waddr = item_addr[sqmix_pkg::REG_AW-1:0];
    wdata = item_data;
    if (cmd.finish) begin
      wen   = 1'b1;
      waddr = {ch, sqmix_pkg::REG_OUTPUT};
      wdata = (cnt_end < half) ? vol : '0;
    end else if (cmd.bus_access && item_mode == sqmix_pkg::MODE_WRITE &&
                 item_addr inside {[sqmix_pkg::ADDR_CHAN_LO:sqmix_pkg::ADDR_CHAN_HI]}) begin
      wen = 1'b1;
    end
  end

  always_comb begin
    rd_next = '0;
    if (item_addr inside {[sqmix_pkg::ADDR_CHAN_LO:sqmix_pkg::ADDR_CHAN_HI]}) begin
      rd_next = rbyte;
    end else if (item_addr inside {[sqmix_pkg::ADDR_ATTEN_LO:sqmix_pkg::ADDR_ATTEN_HI]}) begin
      rd_next = abyte;
    end else if (item_addr == sqmix_pkg::ADDR_PAN) begin
      rd_next = pan_enable;
    end else if (item_addr == sqmix_pkg::ADDR_MUTE) begin
      rd_next = mute_mask;
    end
  end

  always_comb begin
    if (mute_mask[{1'b1, ch}]) lscale = '0;
    else if (pan_enable[{1'b1, ch}]) lscale = abyte[7:4];
    else lscale = sqmix_pkg::FULL_SCALE;
    if (mute_mask[{1'b0, ch}]) rscale = '0;
    else if (pan_enable[{1'b0, ch}]) rscale = abyte[3:0];
    else rscale = sqmix_pkg::FULL_SCALE;
  end

  assign lprod = 13'($signed(raw) * $signed({1'b0, lscale}));
  assign rprod = 13'($signed(raw) * $signed({1'b0, rscale}));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sqmix_pkg::REG_DEPTH; i++) chan_regs[i] <= '0;
      for (int i = 0; i < 4; i++) begin
        atten[i]       <= '0;
        tick_accum[i]  <= '0;
        phase_count[i] <= '0;
      end
      pan_enable <= '0;
      mute_mask  <= '0;
      ch         <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (wen) chan_regs[waddr] <= wdata;
      if (cmd.bus_access && item_mode == sqmix_pkg::MODE_WRITE) begin
        if (item_addr inside {[sqmix_pkg::ADDR_ATTEN_LO:sqmix_pkg::ADDR_ATTEN_HI]}) begin
          atten[item_addr[1:0]] <= item_data;
        end else if (item_addr == sqmix_pkg::ADDR_PAN) begin
          pan_enable <= item_data;
        end else if (item_addr == sqmix_pkg::ADDR_MUTE) begin
          mute_mask <= item_data;
        end
      end
      if (cmd.start_chan) begin
        if (!c1[sqmix_pkg::COUNT_EN_BIT]) begin
          tick_accum[ch]  <= '0;
          phase_count[ch] <= '0;
        end else if (c1[2:0] == sqmix_pkg::LINK_MODE_HOLD) begin
          tick_accum[ch] <= acc_sat;
        end
      end
      if (cmd.finish) begin
        tick_accum[ch]  <= acc;
        phase_count[ch] <= cnt_end;
      end
      if (cmd.capture) ch <= '0;
      else if (cmd.mix && ch != sqmix_pkg::LAST_CH) ch <= ch + 1'b1;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= in_mode;
      item_addr <= in_address;
      item_data <= in_write_data;
      rd_data   <= '0;
      left_sum  <= '0;
      right_sum <= '0;
    end
    if (cmd.bus_access && item_mode == sqmix_pkg::MODE_READ) rd_data <= rd_next;
    case (cmd.rsel)
      sqmix_pkg::RSEL_C1:  c1  <= rbyte;
      sqmix_pkg::RSEL_PER: per <= rbyte;
      sqmix_pkg::RSEL_VOL: vol <= rbyte;
      sqmix_pkg::RSEL_OUT: raw <= rbyte;
      default: ;
    endcase
    if (cmd.start_chan) begin
      acc         <= acc_sat;
      cnt         <= phase_count[ch];
      second_half <= 1'b0;
    end
    if (cmd.step) begin
      if (!second_half) begin
        if (cnt <= half) begin
          acc <= acc - unit;
          cnt <= cnt + 1'b1;
        end else begin
          second_half <= 1'b1;
        end
      end else begin
        if (cnt <= per9) begin
          acc <= acc - unit;
          cnt <= cnt + 1'b1;
        end else begin
          cnt         <= '0;
          second_half <= 1'b0;
        end
      end
    end
    if (cmd.mix) begin
      left_sum  <= left_sum + {lprod[12], lprod};
      right_sum <= right_sum + {rprod[12], rprod};
    end
    if (cmd.load_out) begin
      out_read_data    <= rd_data;
      out_left_sample  <= left_sum;
      out_right_sample <= right_sum;
    end
  end

  assign st.is_tick    = item_tick;
  assign st.chan_en    = c1[sqmix_pkg::COUNT_EN_BIT];
  assign st.chan_hold  = (c1[2:0] == sqmix_pkg::LINK_MODE_HOLD);
  assign st.units_left = units_left;
  assign st.last_ch    = (ch == sqmix_pkg::LAST_CH);
  assign st.out_free   = !out_valid || out_ready;

  a_phase_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> cnt <= sqmix_pkg::PHASE_LIMIT)
    else $error("phase counter ran past the longest period");

  a_residue_small: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> tick_accum[ch] < sqmix_pkg::ACC_RESIDUE_LIMIT)
    else $error("accumulator left a whole prescaled unit unspent");

  a_capture_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> rd_data == '0 && left_sum == '0 && right_sum == '0)
    else $error("result accumulators not cleared for a new transaction");

endmodule

// File: rtl/core/four_channel_square_audio_mixer.sv
`timescale 1ns / 1ps

// Four-channel square-wave mixer. Each input transaction is a register write, a
// register read or a sample tick, and each produces exactly one output transaction.
// Writes, reads and the unused mode pass through the access and result states, and
// the next transaction is accepted once the controller is idle again. A tick walks
// the channels in turn on a single shared phase-step datapath that spends one
// prescaled unit per clock, except on a half-period turnover. A counting channel
// reads its control, counter and volume registers, steps until it has spent
// (accumulator + tick_step) >> prescale units, finishes, reads its output register
// and mixes it. Disabled and hold-mode channels skip the step and finish states.
// A tick also passes the access and result states. A saturated accumulator at
// prescale 0 spends up to 65535 units in one tick. One transaction is in flight at
// a time. A finished result waits in the output register while the next transaction
// is accepted. tick_step is set over APB at addresses 0 to 3 and resets to 22.

module four_channel_square_audio_mixer (
  input  logic                              clk,
  input  logic                              rst,
  sqmix_in_if.sink                          in,
  sqmix_out_if.source                       out,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sqmix_pkg::PADDR_W-1:0]     paddr,
  input  logic [sqmix_pkg::PDATA_W-1:0]     pwdata,
  output logic [sqmix_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  sqmix_pkg::ctrl_cmd_t           cmd;
  sqmix_pkg::dp_status_t          st;
  logic [sqmix_pkg::STEP_W-1:0]   tick_step;
  logic                           cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[sqmix_pkg::PADDR_W-1] == sqmix_pkg::CFG_IDX_TICK_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_step <= sqmix_pkg::TICK_STEP_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      tick_step <= pwdata[sqmix_pkg::STEP_W-1:0];
    end
  end

  assign prdata = cfg_hit ? {{(sqmix_pkg::PDATA_W - sqmix_pkg::STEP_W){1'b0}}, tick_step}
                          : '0;

  sqmix_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_ready (in.ready),
    .st       (st),
    .cmd      (cmd)
  );

  sqmix_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .tick_step        (tick_step),
    .in_mode          (in.mode),
    .in_address       (in.address),
    .in_write_data    (in.write_data),
    .out_ready        (out.ready),
    .out_valid        (out.valid),
    .out_read_data    (out.read_data),
    .out_left_sample  (out.left_sample),
    .out_right_sample (out.right_sample)
  );

endmodule
